### src/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the MIDI control scanner
// Holds the command codes, register indexes, packet codes and the structs
// that pass between the table, the packet formatter and the top level.
// ----------------------------------------------------------------------------
package msc_pkg;

	typedef enum logic [1:0] {
		CMD_MAP    = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_SEND   = 2'd2
	} cmd_t;

	// configuration register indexes
	localparam logic CFG_HOLDOFF   = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	localparam logic [7:0] HOLDOFF_RESET   = 8'd10;
	localparam logic [6:0] THRESHOLD_RESET = 7'd1;

	// USB-MIDI code index numbers and MIDI status bytes, channel 1
	localparam logic [3:0] HDR_NOTE_OFF = 4'd8;
	localparam logic [3:0] HDR_NOTE_ON  = 4'd9;
	localparam logic [3:0] HDR_CONTROL  = 4'd11;
	localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
	localparam logic [7:0] ST_NOTE_ON   = 8'h90;
	localparam logic [7:0] ST_CONTROL   = 8'hB0;
	localparam logic [6:0] VEL_FULL     = 7'h7F;

	// knob readings are 10 bits, stored values 7 bits: drop the low 3 bits
	localparam int KNOB_SHIFT = 3;

	typedef struct packed {
		cmd_t       cmd;
		logic [3:0] element_index;
		logic       element_kind;
		logic [6:0] map_number;
		logic [9:0] sample_value;
	} in_item_t;

	// entry picked for a send
	typedef struct packed {
		logic       hit;
		logic       kind;
		logic [6:0] number;
		logic [6:0] level;
	} sel_entry_t;

	typedef struct packed {
		logic [3:0] packet_header;
		logic [7:0] status_byte;
		logic [6:0] first_data;
		logic [6:0] second_data;
	} pkt_t;

endpackage

### src/msc_if.sv
// ----------------------------------------------------------------------------
// msc_if: word channels of the MIDI control scanner
// One interface for incoming command words, one for outgoing packet words.
// ----------------------------------------------------------------------------
interface msc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [3:0] element_index;
	logic       element_kind;
	logic [6:0] map_number;
	logic [9:0] sample_value;

	modport source (
		output valid, cmd, element_index, element_kind, map_number, sample_value,
		input  ready
	);
	modport sink (
		input  valid, cmd, element_index, element_kind, map_number, sample_value,
		output ready
	);
endinterface

interface msc_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] packet_header;
	logic [7:0] status_byte;
	logic [6:0] first_data;
	logic [6:0] second_data;

	modport source (
		output valid, packet_header, status_byte, first_data, second_data,
		input  ready
	);
	modport sink (
		input  valid, packet_header, status_byte, first_data, second_data,
		output ready
	);
endinterface

### src/midi_control_scanner.sv
// ----------------------------------------------------------------------------
// midi_control_scanner: control-surface scanner emitting USB-MIDI packets
// Maps buttons and knobs, debounces samples with a hold-off, and sends one
// packet for the lowest pending element on each send word.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    cmd, element_index, element_kind, map_number,
//                               sample_value
//  out_ch   out  valid/ready    packet_header, status_byte, first_data,
//                               second_data
//  cfg      in   cfg_we only    cfg_index (0 hold-off, 1 knob threshold), cfg_data
//
//  One word per cycle while the output is not stalled. A word is registered on
//  acceptance, processed by the table and formatter from the input stage, and
//  its packet (if any) is loaded into the output register as the word leaves.
//  The critical path is the pending priority search plus the table read.
//  Reset clears the element count, pending flags, both valid bits and loads
//  the register defaults; table contents need no clearing.
//  A stalled output holds the input stage; the input stage still takes a word
//  when it is empty, so one word can wait behind an unread packet.
// ----------------------------------------------------------------------------
module midi_control_scanner
	import msc_pkg::*;
#(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	msc_in_if.sink     in_ch,
	msc_out_if.source  out_ch
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_valid_q;
	pkt_t       pkt_q;
	logic [7:0] holdoff_q;
	logic [6:0] threshold_q;

	logic       advance;
	logic       fire;
	sel_entry_t sel;
	pkt_t       pkt;

	// advance the input stage whenever the output register is free or drains
	assign advance     = !out_valid_q || out_ch.ready;
	assign fire        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	// configuration registers; writes beyond the list cannot be addressed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q   <= HOLDOFF_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HOLDOFF:   holdoff_q   <= cfg_data;
				CFG_THRESHOLD: threshold_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input stage: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// input stage: payload, held while stalled
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.cmd           <= cmd_t'(in_ch.cmd);
			item_s1.element_index <= in_ch.element_index;
			item_s1.element_kind  <= in_ch.element_kind;
			item_s1.map_number    <= in_ch.map_number;
			item_s1.sample_value  <= in_ch.sample_value;
		end
	end

	msc_table #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_table (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.holdoff_count  (holdoff_q),
		.knob_threshold (threshold_q),
		.sel            (sel)
	);

	msc_packet u_packet (
		.sel (sel),
		.pkt (pkt)
	);

	// output register: only a send that found a pending element makes a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && sel.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && sel.hit) begin
			pkt_q <= pkt;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.packet_header = pkt_q.packet_header;
	assign out_ch.status_byte   = pkt_q.status_byte;
	assign out_ch.first_data    = pkt_q.first_data;
	assign out_ch.second_data   = pkt_q.second_data;

endmodule

### src/msc_table.sv
// ----------------------------------------------------------------------------
// msc_table: element table with sample update and pending search
// Stores kind, number, last value and hold-off per element, appends on map,
// updates on sample and picks the lowest pending element on send.
// ----------------------------------------------------------------------------
module msc_table
	import msc_pkg::*;
#(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_item_t   item,
	input  logic [7:0] holdoff_count,
	input  logic [6:0] knob_threshold,
	output sel_entry_t sel
);

	localparam int IW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW   = $clog2(MAX_ELEMENTS + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;

	logic                    kind_q   [MAX_ELEMENTS];
	logic [6:0]              number_q [MAX_ELEMENTS];
	logic [6:0]              last_q   [MAX_ELEMENTS];
	logic [7:0]              hold_q   [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] pend_q;
	logic [CW-1:0]           count_q;

	logic          any_pend;
	logic [IW-1:0] enc_idx;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] wr_idx;
	logic          map_ok;
	logic          sample_ok;
	logic          rd_kind;
	logic [6:0]    rd_last;
	logic [7:0]    rd_hold;
	logic [6:0]    cur;
	logic [6:0]    diff;
	logic          changed;

	// lowest-numbered pending element wins
	always_comb begin
		any_pend = 1'b0;
		enc_idx  = '0;
		for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				any_pend = 1'b1;
				enc_idx  = IW'(i);
			end
		end
	end

	assign map_ok    = count_q < CW'(MAX_ELEMENTS);
	assign sample_ok = CMPW'(item.element_index) < CMPW'(count_q);
	assign wr_idx    = IW'(count_q);
	assign rd_idx    = (item.cmd == CMD_SEND) ? enc_idx : IW'(item.element_index);

	assign rd_kind = kind_q[rd_idx];
	assign rd_last = last_q[rd_idx];
	assign rd_hold = hold_q[rd_idx];

	always_comb begin
		if (rd_kind) begin
			cur = item.sample_value[9:KNOB_SHIFT];
		end else begin
			cur = {6'd0, item.sample_value[0]};
		end
		diff    = (cur > rd_last) ? (cur - rd_last) : (rd_last - cur);
		changed = rd_kind ? (diff > knob_threshold) : (cur != rd_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= '0;
		end else if (fire) begin
			case (item.cmd)
				CMD_MAP: begin
					if (map_ok) begin
						count_q        <= count_q + 1'b1;
						pend_q[wr_idx] <= 1'b0;
					end
				end
				CMD_SAMPLE: begin
					if (sample_ok && rd_hold == 8'd0 && changed) begin
						pend_q[rd_idx] <= 1'b1;
					end
				end
				CMD_SEND: begin
					if (any_pend) begin
						pend_q[enc_idx] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (item.cmd)
				CMD_MAP: begin
					if (map_ok) begin
						kind_q[wr_idx]   <= item.element_kind;
						number_q[wr_idx] <= item.map_number;
						last_q[wr_idx]   <= 7'd0;
						hold_q[wr_idx]   <= 8'd0;
					end
				end
				CMD_SAMPLE: begin
					if (sample_ok) begin
						if (rd_hold != 8'd0) begin
							hold_q[rd_idx] <= rd_hold - 8'd1;
						end else if (changed) begin
							last_q[rd_idx] <= cur;
							hold_q[rd_idx] <= holdoff_count;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign sel.hit    = (item.cmd == CMD_SEND) && any_pend;
	assign sel.kind   = rd_kind;
	assign sel.number = number_q[rd_idx];
	assign sel.level  = rd_last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("element count beyond table size");

	a_map_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == CMD_MAP && map_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("map with room did not append an element");

	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sel.hit |=> !pend_q[$past(enc_idx)])
		else $error("sent element still pending");

endmodule

### src/msc_packet.sv
// ----------------------------------------------------------------------------
// msc_packet: USB-MIDI packet formatter
// Turns the selected element into header, status and two data bytes.
// ----------------------------------------------------------------------------
module msc_packet
	import msc_pkg::*;
(
	input  sel_entry_t sel,
	output pkt_t       pkt
);

	always_comb begin
		pkt.first_data = sel.number;
		if (sel.kind) begin
			pkt.packet_header = HDR_CONTROL;
			pkt.status_byte   = ST_CONTROL;
			pkt.second_data   = sel.level;
		end else if (sel.level == 7'd1) begin
			pkt.packet_header = HDR_NOTE_OFF;
			pkt.status_byte   = ST_NOTE_OFF;
			pkt.second_data   = 7'd0;
		end else begin
			pkt.packet_header = HDR_NOTE_ON;
			pkt.status_byte   = ST_NOTE_ON;
			pkt.second_data   = VEL_FULL;
		end
	end

endmodule
